// File: hw/rtl/move_to_front_node_table_macros.svh
// assertion macros for the move-to-front node table
// used by modules that check their own control logic; needs clk_i and rst_ni in scope
`ifndef MOVE_TO_FRONT_NODE_TABLE_MACROS_SVH
`define MOVE_TO_FRONT_NODE_TABLE_MACROS_SVH

// property checked at every clock edge out of reset
`define MTF_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mtf_pkg.sv
// shared types and constants for the move-to-front node table
// no dependencies
package mtf_pkg;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic [31:0]        key;
    logic signed [7:0]  snr;
    logic signed [15:0] rssi;
    logic [7:0]         hops;
    logic [31:0]        time_ms;
  } entry_t;

  typedef struct packed {
    logic               operation;
    logic [31:0]        node_key;
    logic signed [7:0]  link_snr;
    logic signed [15:0] link_rssi;
    logic [7:0]         hop_count;
    logic [31:0]        now_ms;
    logic [5:0]         read_index;
  } item_t;

  typedef struct packed {
    logic   entry_valid;
    logic   was_found;
    entry_t entry;
    logic [6:0] table_count;
  } result_t;

  // control handed from the sequencer to every cell
  typedef struct packed {
    logic match_en;
    logic shift_en;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MATCH  = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

endpackage

// File: hw/rtl/mtf_in_if.sv
// input channel of the move-to-front node table: valid, ready and one item
// depends on nothing
interface mtf_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [31:0]        node_key;
  logic signed [7:0]  link_snr;
  logic signed [15:0] link_rssi;
  logic [7:0]         hop_count;
  logic [31:0]        now_ms;
  logic [5:0]         read_index;

  modport source (
    output valid, operation, node_key, link_snr, link_rssi, hop_count, now_ms, read_index,
    input  ready
  );
  modport sink (
    input  valid, operation, node_key, link_snr, link_rssi, hop_count, now_ms, read_index,
    output ready
  );
endinterface

// File: hw/rtl/mtf_out_if.sv
// result channel of the move-to-front node table: valid, ready and one result
// depends on nothing
interface mtf_out_if;
  logic               valid;
  logic               ready;
  logic               entry_valid;
  logic               was_found;
  logic [31:0]        entry_key;
  logic signed [7:0]  entry_snr;
  logic signed [15:0] entry_rssi;
  logic [7:0]         entry_hops;
  logic [31:0]        entry_time;
  logic [6:0]         table_count;

  modport source (
    output valid, entry_valid, was_found, entry_key, entry_snr, entry_rssi, entry_hops,
           entry_time, table_count,
    input  ready
  );
  modport sink (
    input  valid, entry_valid, was_found, entry_key, entry_snr, entry_rssi, entry_hops,
           entry_time, table_count,
    output ready
  );
endinterface

// File: hw/rtl/mtf_cell.sv
// one table position: holds an entry, compares its key, takes its left neighbor's entry
// depends on mtf_pkg
module mtf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtf_pkg::cell_ctl_t ctl_i,
  input  logic [31:0]        key_i,
  input  logic               live_i,     // position holds a written entry
  input  logic               reach_i,    // position is within count, may take a shift
  input  logic               hit_i,      // a position nearer the front matched
  input  mtf_pkg::entry_t    shift_in_i,
  output logic               hit_o,
  output mtf_pkg::entry_t    entry_o
);

  logic            match_q;
  mtf_pkg::entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.match_en) begin
      match_q <= live_i && (entry_q.key == key_i);
    end
  end

  // positions up to the first match, or up to the count, shift down by one
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_en && reach_i && !hit_i) begin
      entry_q <= shift_in_i;
    end
  end

  assign hit_o   = hit_i | match_q;
  assign entry_o = entry_q;

endmodule

// File: hw/rtl/mtf_ctrl.sv
// sequencer of the move-to-front node table: item register, state machine, entry count
// depends on mtf_pkg and move_to_front_node_table_macros.svh
`include "move_to_front_node_table_macros.svh"

module mtf_ctrl #(
  parameter int TABLE_DEPTH = 16,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  mtf_pkg::item_t     in_item_i,
  output logic               in_ready_o,
  input  logic               out_stall_i,
  input  logic               found_i,
  output mtf_pkg::cell_ctl_t ctl_o,
  output logic               load_o,
  output mtf_pkg::item_t     item_o,
  output logic [CW-1:0]      count_o,
  output logic [CW-1:0]      count_next_o
);

  mtf_pkg::state_e state_q, state_d;
  mtf_pkg::item_t  item_q;
  logic [CW-1:0]   count_q, count_d;

  assign in_ready_o = (state_q == mtf_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtf_pkg::S_IDLE:   if (in_valid_i) state_d = mtf_pkg::S_MATCH;
      mtf_pkg::S_MATCH:  state_d = mtf_pkg::S_UPDATE;
      mtf_pkg::S_UPDATE: if (!out_stall_i) state_d = mtf_pkg::S_IDLE;
      default:           state_d = mtf_pkg::S_IDLE;
    endcase
  end

  assign load_o         = (state_q == mtf_pkg::S_UPDATE) && !out_stall_i;
  assign ctl_o.match_en = (state_q == mtf_pkg::S_MATCH);
  assign ctl_o.shift_en = load_o && (item_q.operation == mtf_pkg::OP_RECORD);

  // a new key grows the table until it is full
  always_comb begin
    count_d = count_q;
    if (ctl_o.shift_en && !found_i && (count_q != CW'(TABLE_DEPTH))) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtf_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_o       = item_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

  `MTF_ASSERT_CLK(a_count_bound, count_q <= CW'(TABLE_DEPTH), "count above table depth")
  `MTF_ASSERT_NEXT(a_count_hold, !ctl_o.shift_en, $stable(count_q), "count moved without record")
  `MTF_ASSERT_NEXT(a_count_step, ctl_o.shift_en,
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)), "count jumped")
  `MTF_ASSERT_NEXT(a_accept_match, in_valid_i && in_ready_o, state_q == mtf_pkg::S_MATCH,
    "accepted beat did not start a compare")

endmodule

// File: hw/rtl/move_to_front_node_table.sv
// move-to-front node table: an accepted item passes the compare state, then the update state sets result valid
// one item at a time: accept, key compare in the cell row, then shift and load
// the shift cycle waits while a result still sits unaccepted in the output register
// the next item is taken while a result still waits in the output register
// reset clears the entry count and the handshake state; stored entries are undefined until written
// depends on mtf_pkg, mtf_in_if, mtf_out_if, mtf_ctrl and mtf_cell
module move_to_front_node_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtf_in_if.sink    in_i,
  mtf_out_if.source out_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  mtf_pkg::item_t     in_item, item;
  mtf_pkg::cell_ctl_t ctl;
  mtf_pkg::entry_t    new_entry;
  mtf_pkg::entry_t    entry_w [TABLE_DEPTH];
  logic               hit_w [TABLE_DEPTH + 1];
  logic [CW-1:0]      count, count_next;
  logic               load, stall, found, read_ok;
  logic               out_valid_q;
  mtf_pkg::result_t   result_q, result_d;

  assign in_item.operation  = in_i.operation;
  assign in_item.node_key   = in_i.node_key;
  assign in_item.link_snr   = in_i.link_snr;
  assign in_item.link_rssi  = in_i.link_rssi;
  assign in_item.hop_count  = in_i.hop_count;
  assign in_item.now_ms     = in_i.now_ms;
  assign in_item.read_index = in_i.read_index;

  assign stall = out_valid_q && !out_o.ready;

  mtf_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (in_i.ready),
    .out_stall_i  (stall),
    .found_i      (found),
    .ctl_o        (ctl),
    .load_o       (load),
    .item_o       (item),
    .count_o      (count),
    .count_next_o (count_next)
  );

  assign new_entry.key     = item.node_key;
  assign new_entry.snr     = item.link_snr;
  assign new_entry.rssi    = item.link_rssi;
  assign new_entry.hops    = item.hop_count;
  assign new_entry.time_ms = item.now_ms;

  assign hit_w[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    mtf_pkg::entry_t shift_in;

    if (i == 0) begin : g_head
      assign shift_in = new_entry;
    end else begin : g_body
      assign shift_in = entry_w[i-1];
    end

    mtf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .key_i      (item.node_key),
      .live_i     (Idx < count),
      .reach_i    (Idx <= count),
      .hit_i      (hit_w[i]),
      .shift_in_i (shift_in),
      .hit_o      (hit_w[i+1]),
      .entry_o    (entry_w[i])
    );
  end

  assign found   = hit_w[TABLE_DEPTH];
  assign read_ok = 7'(item.read_index) < 7'(count);

  always_comb begin
    result_d.table_count = 7'(count_next);
    if (item.operation == mtf_pkg::OP_RECORD) begin
      result_d.entry_valid = 1'b1;
      result_d.was_found   = found;
      result_d.entry       = new_entry;
    end else begin
      result_d.entry_valid = read_ok;
      result_d.was_found   = 1'b0;
      result_d.entry       = read_ok ? entry_w[item.read_index[IW-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_valid = result_q.entry_valid;
  assign out_o.was_found   = result_q.was_found;
  assign out_o.entry_key   = result_q.entry.key;
  assign out_o.entry_snr   = result_q.entry.snr;
  assign out_o.entry_rssi  = result_q.entry.rssi;
  assign out_o.entry_hops  = result_q.entry.hops;
  assign out_o.entry_time  = result_q.entry.time_ms;
  assign out_o.table_count = result_q.table_count;

endmodule
